// ===== hdl/atc_pkg.sv =====
// Shared types and constants of the tile auto-tiling block.
`default_nettype none

package atc_pkg;

   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [4:0] CODE_EDGE_BASE = 5'd16;
   localparam logic [4:0] CODE_SOLID     = 5'd20;

   typedef enum logic [2:0] {
      OP_SET,
      OP_CLEAR,
      OP_QUERY,
      OP_PEEK,
      OP_OUTSIDE
   } op_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] tile_x;
      logic [7:0] tile_y;
   } req_type;

   typedef struct packed {
      logic [4:0] tile_code;
      logic       tile_filled;
      logic       out_of_range;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] tile_x;
      logic [7:0] tile_y;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/tile_neighbor_autotile_code.sv =====
// Top level of the tile auto-tiling block.
//
//   channel   direction  handshake          payload
//   req_      in         req_push/req_full  atc_pkg::req_type (mode, tile_x, tile_y)
//   rsp_      out        rsp_empty/rsp_pop  atc_pkg::rsp_type (tile_code, tile_filled,
//                                           out_of_range)
//
// A request is registered in the command queue, then the sequencer takes it.
// A query of a filled tile takes five row reads of the row-wide map; set, clear and
// empty query read one row, and a request outside the grid reads none.
// Reset clears the queues and the per-row valid bits; no clearing pass is needed.
// Either side may stall; the sequencer waits while the response queue is full.
`default_nettype none

module tile_neighbor_autotile_code #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire atc_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output atc_pkg::rsp_type      rsp_data
);

   logic             cmd_valid;
   logic             cmd_pop;
   atc_pkg::cmd_type cmd_data;

   atc_front #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   atc_back #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/atc_front.sv =====
// Request intake: range check, operation decode and command queue.
`default_nettype none

module atc_front #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire atc_pkg::req_type req_data,
   output logic                 cmd_valid,
   input  wire logic            cmd_pop,
   output atc_pkg::cmd_type     cmd_data
);

   atc_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;
   atc_pkg::cmd_type cmd_new;

   always_comb begin
      cmd_new.tile_x = req_data.tile_x;
      cmd_new.tile_y = req_data.tile_y;
      if (({1'b0, req_data.tile_x} >= 9'(GRID_W)) || ({1'b0, req_data.tile_y} >= 9'(GRID_H))) begin
         cmd_new.op = atc_pkg::OP_OUTSIDE;
      end else begin
         case (req_data.mode)
            atc_pkg::MODE_SET:   cmd_new.op = atc_pkg::OP_SET;
            atc_pkg::MODE_CLEAR: cmd_new.op = atc_pkg::OP_CLEAR;
            atc_pkg::MODE_QUERY: cmd_new.op = atc_pkg::OP_QUERY;
            default:             cmd_new.op = atc_pkg::OP_PEEK;
         endcase
      end
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/atc_back.sv =====
// Command execution: row-wide tile map, neighbor gather, code and response queue.
`default_nettype none

module atc_back #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire atc_pkg::cmd_type cmd_data,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output atc_pkg::rsp_type      rsp_data
);

   localparam int RowW    = $clog2(GRID_H);
   localparam int XW      = $clog2(GRID_W);
   localparam int PadW    = GRID_W + 4;
   localparam int PadIdxW = $clog2(PadW);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CENTER,
      S_ROWS,
      S_EVAL
   } state_type;

   function automatic logic [9:0] row_target(input logic [7:0] y, input logic [1:0] step);
      logic [9:0] off;
      case (step)
         2'd0:    off = -10'sd2;
         2'd1:    off = -10'sd1;
         2'd2:    off = 10'sd1;
         default: off = 10'sd2;
      endcase
      return {2'b00, y} + off;
   endfunction

   function automatic logic [4:0] code_of(input logic [11:0] nb);
      logic [3:0] near;
      logic [2:0] far;
      logic [2:0] slot;
      logic [4:0] code;
      near = 4'd0;
      far  = 3'd0;
      slot = 3'd0;
      for (int n = 0; n < 8; n++) begin
         near = near + 4'(nb[n]);
         if (!nb[n]) begin
            slot = 3'(n);
         end
      end
      for (int n = 8; n < 12; n++) begin
         far = far + 3'(nb[n]);
      end
      if ((near == 4'd7) && slot[2]) begin
         code = atc_pkg::CODE_EDGE_BASE + {3'b000, slot[1:0]};
      end else if ((near == 4'd8) && (far == 3'd4)) begin
         code = atc_pkg::CODE_SOLID;
      end else begin
         code = {1'b0, nb[3:0]};
      end
      return code;
   endfunction

   // tile map
   logic [GRID_W-1:0] mem [GRID_H];
   logic [GRID_H-1:0] row_valid_ff;
   logic [GRID_W-1:0] rdata_ff;
   logic              rvalid_ff;
   logic [RowW-1:0]   raddr;
   logic              wr_en;
   logic [RowW-1:0]   waddr;
   logic [GRID_W-1:0] wdata;

   // sequencer
   state_type        state_ff, state_in;
   atc_pkg::cmd_type cmd_ff, cmd_in;
   logic [1:0]       step_ff, step_in;
   logic             rin_ff, rin_in;
   logic [4:0]       win_c_ff, win_c_in;
   logic [4:0]       win_m2_ff, win_m2_in;
   logic [4:0]       win_m1_ff, win_m1_in;
   logic [4:0]       win_p1_ff, win_p1_in;
   logic [4:0]       win_p2_ff, win_p2_in;

   logic [GRID_W-1:0] row_eff;
   logic [PadW-1:0]   padded;
   logic [4:0]        win_cur;
   logic [11:0]       nb;
   logic [9:0]        tgt;
   logic [1:0]        tgt_step;

   // response queue
   atc_pkg::rsp_type res_q_ff [2];
   logic             res_wr_ff, res_wr_in;
   logic             res_rd_ff, res_rd_in;
   logic [1:0]       res_cnt_ff, res_cnt_in;
   logic             res_push, res_pop;
   atc_pkg::rsp_type res_data;

   assign row_eff = rvalid_ff ? rdata_ff : '0;
   assign padded  = {2'b11, row_eff, 2'b11};
   assign win_cur = rin_ff ? padded[PadIdxW'(cmd_ff.tile_x) +: 5] : 5'b11111;
   assign tgt     = row_target(cmd_ff.tile_y, tgt_step);

   assign nb = {win_p2_ff[2], win_c_ff[4], win_c_ff[0], win_m2_ff[2],
                win_p1_ff[3], win_p1_ff[1], win_m1_ff[3], win_m1_ff[1],
                win_p1_ff[2], win_c_ff[3], win_c_ff[1], win_m1_ff[2]};

   assign waddr = RowW'(cmd_ff.tile_y);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      step_in   = step_ff;
      rin_in    = rin_ff;
      win_c_in  = win_c_ff;
      win_m2_in = win_m2_ff;
      win_m1_in = win_m1_ff;
      win_p1_in = win_p1_ff;
      win_p2_in = win_p2_ff;
      raddr     = '0;
      tgt_step  = 2'd0;
      wr_en     = 1'b0;
      wdata     = row_eff;
      cmd_pop   = 1'b0;
      res_push  = 1'b0;
      res_data  = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && (res_cnt_ff != 2'd2)) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               if (cmd_data.op == atc_pkg::OP_OUTSIDE) begin
                  res_push              = 1'b1;
                  res_data.out_of_range = 1'b1;
               end else begin
                  raddr    = RowW'(cmd_data.tile_y);
                  rin_in   = 1'b1;
                  state_in = S_CENTER;
               end
            end
         end
         S_CENTER: begin
            win_c_in = win_cur;
            state_in = S_IDLE;
            case (cmd_ff.op)
               atc_pkg::OP_SET: begin
                  wr_en                       = 1'b1;
                  wdata[XW'(cmd_ff.tile_x)]   = 1'b1;
                  res_push                    = 1'b1;
                  res_data.tile_filled        = 1'b1;
               end
               atc_pkg::OP_CLEAR: begin
                  wr_en                       = 1'b1;
                  wdata[XW'(cmd_ff.tile_x)]   = 1'b0;
                  res_push                    = 1'b1;
               end
               atc_pkg::OP_QUERY: begin
                  if (!win_cur[2]) begin
                     res_push = 1'b1;
                  end else begin
                     tgt_step = 2'd0;
                     rin_in   = !tgt[9] && (tgt[8:0] < 9'(GRID_H));
                     raddr    = rin_in ? RowW'(tgt) : '0;
                     step_in  = 2'd0;
                     state_in = S_ROWS;
                  end
               end
               atc_pkg::OP_PEEK: begin
                  res_push             = 1'b1;
                  res_data.tile_filled = win_cur[2];
               end
               default: begin
                  res_push              = 1'b1;
                  res_data.out_of_range = 1'b1;
               end
            endcase
         end
         S_ROWS: begin
            case (step_ff)
               2'd0:    win_m2_in = win_cur;
               2'd1:    win_m1_in = win_cur;
               2'd2:    win_p1_in = win_cur;
               default: win_p2_in = win_cur;
            endcase
            if (step_ff == 2'd3) begin
               state_in = S_EVAL;
            end else begin
               tgt_step = step_ff + 2'd1;
               rin_in   = !tgt[9] && (tgt[8:0] < 9'(GRID_H));
               raddr    = rin_in ? RowW'(tgt) : '0;
               step_in  = step_ff + 2'd1;
            end
         end
         S_EVAL: begin
            res_push             = 1'b1;
            res_data.tile_filled = 1'b1;
            res_data.tile_code   = code_of(nb);
            state_in             = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cmd_ff    <= '0;
         step_ff   <= 2'd0;
         rin_ff    <= 1'b0;
         win_c_ff  <= '0;
         win_m2_ff <= '0;
         win_m1_ff <= '0;
         win_p1_ff <= '0;
         win_p2_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cmd_ff    <= cmd_in;
         step_ff   <= step_in;
         rin_ff    <= rin_in;
         win_c_ff  <= win_c_in;
         win_m2_ff <= win_m2_in;
         win_m1_ff <= win_m1_in;
         win_p1_ff <= win_p1_in;
         win_p2_ff <= win_p2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[waddr] <= 1'b1;
         end
         rvalid_ff <= row_valid_ff[raddr];
      end
   end

   assign rsp_empty = (res_cnt_ff == 2'd0);
   assign rsp_data  = res_q_ff[res_rd_ff];
   assign res_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      res_wr_in = res_push ? !res_wr_ff : res_wr_ff;
      res_rd_in = res_pop ? !res_rd_ff : res_rd_ff;
      case ({res_push, res_pop})
         2'b10:   res_cnt_in = res_cnt_ff + 2'd1;
         2'b01:   res_cnt_in = res_cnt_ff - 2'd1;
         default: res_cnt_in = res_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         res_wr_ff  <= res_wr_in;
         res_rd_ff  <= res_rd_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_q_ff[res_wr_ff] <= res_data;
      end
   end

`ifndef ASSERT_OFF
   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (res_cnt_ff != 2'd2))
      else $error("response queue overflow");

   a_outside_clean: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data.out_of_range) |->
         ((res_data.tile_code == 5'd0) && !res_data.tile_filled))
      else $error("out-of-range response carries tile data");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (res_data.tile_code <= atc_pkg::CODE_SOLID))
      else $error("tile code beyond range");

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> row_valid_ff[$past(waddr)])
      else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the tile auto-tiling block: directed and random requests checked against a bitmap predictor.
`timescale 1ns / 100ps

module tb;

   localparam int GRID_W = 64;
   localparam int GRID_H = 64;
   localparam logic [1:0] MODE_PEEK = 2'd3;
   localparam int NUM_RANDOM = 1000;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      atc_pkg::req_type req;
      bit               wait_drain;
   } stim_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   atc_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   atc_pkg::rsp_type rsp_data;

   stim_type         pending[$];
   atc_pkg::rsp_type rsp_expected[$];
   bit               tile_map [GRID_H][GRID_W];
   int               nb_dx [12] = '{0, -1, 1, 0, -1, 1, -1, 1, 0, -2, 2, 0};
   int               nb_dy [12] = '{-1, 0, 0, 1, -1, -1, 1, 1, -2, 0, 0, 2};

   int fail_count = 0;
   int mismatch_count = 0;
   int n_checked = 0;
   int n_filled_query = 0;
   int n_hole_code = 0;
   int n_solid_code = 0;
   int n_outside = 0;

   tile_neighbor_autotile_code #(
      .GRID_W(GRID_W),
      .GRID_H(GRID_H)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [4:0] autotile_code(int x, int y);
      logic [11:0] nbr;
      int          near_cnt;
      int          far_cnt;
      int          hole;
      int          nx;
      int          ny;
      near_cnt = 0;
      far_cnt = 0;
      hole = 0;
      for (int n = 0; n < 12; n++) begin
         nx = x + nb_dx[n];
         ny = y + nb_dy[n];
         if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H) begin
            nbr[n] = 1'b1;
         end else begin
            nbr[n] = tile_map[ny][nx];
         end
         if (nbr[n]) begin
            if (n < 8) near_cnt++;
            else far_cnt++;
         end else if (n < 8) begin
            hole = n;
         end
      end
      if (near_cnt == 7 && hole >= 4) return atc_pkg::CODE_EDGE_BASE + 5'(hole - 4);
      if (near_cnt == 8 && far_cnt == 4) return atc_pkg::CODE_SOLID;
      return {1'b0, nbr[3:0]};
   endfunction

   function automatic atc_pkg::rsp_type apply_request(atc_pkg::req_type r);
      atc_pkg::rsp_type o;
      int               x;
      int               y;
      o = '0;
      x = r.tile_x;
      y = r.tile_y;
      if (x >= GRID_W || y >= GRID_H) begin
         o.out_of_range = 1'b1;
         return o;
      end
      case (r.mode)
         atc_pkg::MODE_SET: tile_map[y][x] = 1'b1;
         atc_pkg::MODE_CLEAR: tile_map[y][x] = 1'b0;
         default: ;
      endcase
      o.tile_filled = tile_map[y][x];
      if (r.mode == atc_pkg::MODE_QUERY && o.tile_filled) o.tile_code = autotile_code(x, y);
      return o;
   endfunction

   task automatic add_request(logic [1:0] mode, int x, int y, bit wait_drain);
      stim_type s;
      s.req.mode = mode;
      s.req.tile_x = 8'(x);
      s.req.tile_y = 8'(y);
      s.wait_drain = wait_drain;
      pending.push_back(s);
   endtask

   // driver
   stim_type cur_item;
   int       burst_left = 0;
   int       gap_left = 0;
   bit       offer;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            cur_item = pending.pop_front();
            rsp_expected.push_back(apply_request(cur_item.req));
            burst_left--;
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
         end
         offer = gap_left == 0 && pending.size() > 0
               && !(pending[0].wait_drain && rsp_expected.size() > 0);
         req_push <= offer;
         if (offer) req_data <= pending[0].req;
      end
   end

   // receiver
   logic [15:0] stall_pat = '0;
   int          recv_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) recv_count++;
         if (recv_count == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if ($urandom_range(199) == 0) begin
            case ($urandom_range(2))
               0: stall_pat = '0;
               1: stall_pat = 16'($urandom);
               default: stall_pat = 16'($urandom) | 16'($urandom);
            endcase
         end
         stall_pat = {stall_pat[0], stall_pat[15:1]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !stall_pat[0];
         end
      end
   end

   // monitor
   atc_pkg::rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rsp_expected.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected response code=%0d filled=%0b outside=%0b",
                        rsp_data.tile_code, rsp_data.tile_filled, rsp_data.out_of_range);
         end else begin
            want = rsp_expected.pop_front();
            n_checked++;
            if (want.out_of_range) n_outside++;
            if (want.tile_filled && want.tile_code != 0) n_filled_query++;
            if (want.tile_code >= atc_pkg::CODE_EDGE_BASE
                  && want.tile_code < atc_pkg::CODE_SOLID) n_hole_code++;
            if (want.tile_code == atc_pkg::CODE_SOLID) n_solid_code++;
            if (rsp_data.tile_code !== want.tile_code
                  || rsp_data.tile_filled !== want.tile_filled
                  || rsp_data.out_of_range !== want.out_of_range) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: response %0d expected code=%0d filled=%0b outside=%0b",
                           n_checked, want.tile_code, want.tile_filled, want.out_of_range);
                  $display("       got code=%0d filled=%0b outside=%0b",
                           rsp_data.tile_code, rsp_data.tile_filled, rsp_data.out_of_range);
               end
            end
         end
      end
   end

   // watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles, %0d responses outstanding",
                     idle_cycles, rsp_expected.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int n_random;
      int bx;
      int by;
      int len;
      int roll;
      int x;
      int y;
      logic [1:0] mode;

      // directed: empty query, corner codes, solid and hole codes, unused mode, outside grid
      add_request(atc_pkg::MODE_QUERY, 5, 5, 1'b0);
      add_request(atc_pkg::MODE_SET, 0, 0, 1'b0);
      add_request(atc_pkg::MODE_QUERY, 0, 0, 1'b0);
      add_request(atc_pkg::MODE_SET, 1, 0, 1'b0);
      add_request(atc_pkg::MODE_SET, 0, 1, 1'b0);
      add_request(atc_pkg::MODE_SET, 1, 1, 1'b0);
      add_request(atc_pkg::MODE_SET, 2, 0, 1'b0);
      add_request(atc_pkg::MODE_SET, 0, 2, 1'b0);
      add_request(atc_pkg::MODE_QUERY, 0, 0, 1'b0);
      add_request(atc_pkg::MODE_CLEAR, 1, 1, 1'b0);
      add_request(atc_pkg::MODE_QUERY, 0, 0, 1'b0);
      add_request(MODE_PEEK, 0, 0, 1'b0);
      add_request(MODE_PEEK, 1, 1, 1'b0);
      add_request(atc_pkg::MODE_SET, 255, 255, 1'b0);
      add_request(atc_pkg::MODE_QUERY, GRID_W, 0, 1'b0);
      add_request(atc_pkg::MODE_CLEAR, 0, GRID_H, 1'b0);
      add_request(MODE_PEEK, 128, 7, 1'b0);
      add_request(atc_pkg::MODE_SET, GRID_W - 1, GRID_H - 1, 1'b0);
      add_request(atc_pkg::MODE_QUERY, GRID_W - 1, GRID_H - 1, 1'b0);
      add_request(atc_pkg::MODE_QUERY, GRID_W - 1, GRID_H - 2, 1'b0);

      // random: dense writes and queries inside small windows, some outside the grid
      n_random = 0;
      while (n_random < NUM_RANDOM) begin
         case ($urandom_range(3))
            0: bx = 0;
            1: bx = GRID_W - 5;
            default: bx = $urandom_range(GRID_W - 5);
         endcase
         case ($urandom_range(3))
            0: by = 0;
            1: by = GRID_H - 5;
            default: by = $urandom_range(GRID_H - 5);
         endcase
         len = $urandom_range(10, 40);
         for (int k = 0; k < len && n_random < NUM_RANDOM; k++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               mode = 2'($urandom);
               if ($urandom_range(1)) begin
                  x = $urandom_range(255, GRID_W);
                  y = $urandom_range(255);
               end else begin
                  x = $urandom_range(255);
                  y = $urandom_range(255, GRID_H);
               end
            end else begin
               x = bx + $urandom_range(4);
               y = by + $urandom_range(4);
               roll = $urandom_range(99);
               if (roll < 55) mode = atc_pkg::MODE_SET;
               else if (roll < 65) mode = atc_pkg::MODE_CLEAR;
               else if (roll < 95) mode = atc_pkg::MODE_QUERY;
               else mode = MODE_PEEK;
            end
            add_request(mode, x, y, n_random == 0 || n_random == NUM_RANDOM / 2);
            n_random++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() > 0 || rsp_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d coded queries of filled tiles, %0d hole codes,",
               n_checked, n_filled_query, n_hole_code);
      $display("%0d solid codes, %0d requests outside the grid, %0d mismatches",
               n_solid_code, n_outside, mismatch_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
